FILE: rtl/vfbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfbc_pkg: shared types and the micro-op program for the frustum box culler
// Holds the scratch memory map, operand codes and the sequencer program ROM.
// ----------------------------------------------------------------------------
package vfbc_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int PLANE_WIDTH_DEF = 64;

	localparam int MEM_DEPTH = 128;
	localparam int MEM_AW    = 7;
	localparam int PC_W      = 8;

	localparam int BOTTOM_SCALE = 62915;

	// request types
	localparam logic [2:0] REQ_RIGHT = 3'd0;
	localparam logic [2:0] REQ_UP    = 3'd1;
	localparam logic [2:0] REQ_FRONT = 3'd2;
	localparam logic [2:0] REQ_BUILD = 3'd3;
	localparam logic [2:0] REQ_TEST  = 3'd4;

	// micro-op codes
	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_NEG  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_TEST = 3'd4;

	// scratch memory map
	localparam int MA_AXES = 0;
	localparam int MA_NORM = 9;
	localparam int MA_OFFS = 27;
	localparam int MA_HW   = 33;
	localparam int MA_RS   = 34;
	localparam int MA_CTR  = 38;
	localparam int MA_R    = 40;
	localparam int MA_U    = 42;
	localparam int MA_T    = 44;
	localparam int MA_CRN  = 48;
	localparam int MA_V    = 72;
	localparam int MA_UV   = 75;
	localparam int MA_P0   = 81;
	localparam int MA_P1   = 82;
	localparam int MA_D    = 83;
	localparam int MA_BMIN = 84;
	localparam int MA_BMAX = 87;
	localparam int MA_PM   = 90;
	localparam int MA_SUM  = 96;

	// operands outside the memory (bit 7 set)
	localparam logic [7:0] SRC_TAN    = 8'd128;
	localparam logic [7:0] SRC_ASPECT = 8'd129;
	localparam logic [7:0] SRC_NEAR   = 8'd130;
	localparam logic [7:0] SRC_FAR    = 8'd131;
	localparam logic [7:0] SRC_BSCALE = 8'd132;
	localparam logic [7:0] SRC_ZERO   = 8'd133;
	localparam logic [7:0] SRC_A0     = 8'd134;
	localparam logic [7:0] SRC_A1     = 8'd135;
	localparam logic [7:0] SRC_A2     = 8'd136;
	localparam logic [7:0] SRC_MX0    = 8'd137;
	localparam logic [7:0] SRC_MX1    = 8'd138;
	localparam logic [7:0] SRC_MX2    = 8'd139;
	localparam logic [7:0] SRC_EP0    = 8'd140;
	localparam logic [7:0] SRC_EP1    = 8'd141;
	localparam logic [7:0] SRC_EP2    = 8'd142;

	// program entry points
	localparam int ROM_DEPTH  = 231;
	localparam int PC_LOAD    = 0;
	localparam int PC_BUILD   = 3;
	localparam int PC_TEST    = 195;
	localparam int LOOP_START = 201;
	localparam int PLANE_LAST = 5;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] src_a;
		logic [7:0] src_b;
		logic [6:0] dst;
		logic       rel_a3;
		logic       rel_b1;
		logic       rel_d3;
		logic       first;
		logic       last;
		logic       loop;
		logic       done;
	} uop_t;

	typedef uop_t [ROM_DEPTH-1:0] rom_t;

	function automatic logic outside_pos(input logic [2:0] p);
		return (p == 3'd0) || (p == 3'd3) || (p == 3'd4);
	endfunction

	function automatic int plane_pt(input int p, input int j);
		int r;
		r = 0;
		case (p)
			0: r = (j == 0) ? 0 : (j == 1) ? 1 : 3;
			1: r = (j == 0) ? 4 : (j == 1) ? 5 : 7;
			2: r = (j == 0) ? 0 : (j == 1) ? 1 : 5;
			3: r = (j == 0) ? 2 : (j == 1) ? 3 : 7;
			4: r = (j == 0) ? 7 : (j == 1) ? 3 : 5;
			default: r = (j == 0) ? 6 : (j == 1) ? 2 : 4;
		endcase
		return r;
	endfunction

	function automatic uop_t mk(input logic [2:0] op, input int a, input int b, input int d);
		uop_t u;
		u = '0;
		u.op = op;
		u.src_a = 8'(a);
		u.src_b = 8'(b);
		u.dst = 7'(d);
		return u;
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		int n, i, k, s, b, p, pa, pb, pc, nb;
		r = '0;
		n = 0;
		// axis loads: destination offset by three times the axis index
		for (i = 0; i < 3; i++) begin
			r[n] = mk(OP_ADD, SRC_A0 + i, SRC_ZERO, MA_AXES + i);
			r[n].rel_d3 = 1'b1;
			n++;
		end
		r[n-1].done = 1'b1;
		// plane build: scales
		r[n] = mk(OP_MUL, SRC_TAN, SRC_ASPECT, MA_HW); n++;
		r[n] = mk(OP_MUL, MA_HW, SRC_FAR, MA_RS); n++;
		r[n] = mk(OP_MUL, SRC_TAN, SRC_FAR, MA_RS + 1); n++;
		r[n] = mk(OP_MUL, MA_HW, SRC_NEAR, MA_RS + 2); n++;
		r[n] = mk(OP_MUL, SRC_TAN, SRC_NEAR, MA_RS + 3); n++;
		// corners, one axis at a time
		for (i = 0; i < 3; i++) begin
			r[n] = mk(OP_MUL, SRC_FAR, MA_AXES + 6 + i, MA_P0); n++;
			r[n] = mk(OP_ADD, SRC_A0 + i, MA_P0, MA_CTR); n++;
			r[n] = mk(OP_MUL, SRC_NEAR, MA_AXES + 6 + i, MA_P0); n++;
			r[n] = mk(OP_SUB, SRC_A0 + i, MA_P0, MA_CTR + 1); n++;
			for (s = 0; s < 2; s++) begin
				r[n] = mk(OP_MUL, MA_RS + 2*s, MA_AXES + i, MA_R + s); n++;
				r[n] = mk(OP_MUL, MA_RS + 2*s + 1, MA_AXES + 3 + i, MA_U + s); n++;
			end
			for (s = 0; s < 2; s++) begin
				for (b = 0; b < 2; b++) begin
					r[n] = mk((b != 0) ? OP_ADD : OP_SUB, MA_CTR + s, MA_R + s,
						MA_T + 2*s + b);
					n++;
				end
			end
			for (k = 0; k < 8; k++) begin
				s = (k >> 2) & 1;
				b = k & 1;
				r[n] = mk(((k & 2) != 0) ? OP_SUB : OP_ADD, MA_T + 2*s + b, MA_U + s,
					MA_CRN + 3*k + i);
				n++;
			end
		end
		// planes
		for (p = 0; p < 6; p++) begin
			pa = MA_CRN + 3*plane_pt(p, 0);
			pb = MA_CRN + 3*plane_pt(p, 1);
			pc = MA_CRN + 3*plane_pt(p, 2);
			nb = MA_NORM + 3*p;
			for (i = 0; i < 3; i++) begin
				r[n] = mk(OP_SUB, pb + i, pa + i, MA_V + i); n++;
				r[n] = mk(OP_SUB, pc + i, pa + i, MA_UV + i); n++;
			end
			r[n] = mk(OP_MUL, MA_V + 1, MA_UV + 2, MA_P0); n++;
			r[n] = mk(OP_MUL, MA_V + 2, MA_UV + 1, MA_P1); n++;
			r[n] = mk(OP_SUB, MA_P0, MA_P1, nb); n++;
			r[n] = mk(OP_MUL, MA_V + 2, MA_UV + 0, MA_P0); n++;
			r[n] = mk(OP_MUL, MA_V + 0, MA_UV + 2, MA_P1); n++;
			r[n] = mk(OP_SUB, MA_P0, MA_P1, nb + 1); n++;
			r[n] = mk(OP_MUL, MA_V + 0, MA_UV + 1, MA_P0); n++;
			r[n] = mk(OP_MUL, MA_V + 1, MA_UV + 0, MA_P1); n++;
			r[n] = mk(OP_SUB, MA_P0, MA_P1, nb + 2); n++;
			r[n] = mk(OP_MUL, nb, pa, MA_P0); n++;
			r[n] = mk(OP_MUL, nb + 1, pa + 1, MA_P1); n++;
			r[n] = mk(OP_ADD, MA_P0, MA_P1, MA_D); n++;
			r[n] = mk(OP_MUL, nb + 2, pa + 2, MA_P0); n++;
			r[n] = mk(OP_ADD, MA_D, MA_P0, MA_D); n++;
			r[n] = mk(OP_NEG, MA_D, SRC_ZERO, (p == 3) ? MA_D : MA_OFFS + p); n++;
			if (p == 3) begin
				r[n] = mk(OP_MUL, MA_D, SRC_BSCALE, MA_OFFS + 3); n++;
			end
		end
		r[n-1].done = 1'b1;
		// box test: corner coordinates
		for (i = 0; i < 3; i++) begin
			r[n] = mk(OP_ADD, SRC_A0 + i, SRC_EP0 + i, MA_BMIN + i); n++;
			r[n] = mk(OP_ADD, SRC_MX0 + i, SRC_EP0 + i, MA_BMAX + i); n++;
		end
		// per plane body, looped six times
		for (i = 0; i < 3; i++) begin
			for (b = 0; b < 2; b++) begin
				r[n] = mk(OP_MUL, MA_NORM + i, (b != 0) ? MA_BMAX + i : MA_BMIN + i,
					MA_PM + 2*i + b);
				r[n].rel_a3 = 1'b1;
				n++;
			end
		end
		for (k = 0; k < 8; k++) begin
			r[n] = mk(OP_ADD, MA_PM + (k & 1), MA_PM + 2 + ((k >> 1) & 1), MA_SUM); n++;
			r[n] = mk(OP_ADD, MA_SUM, MA_PM + 4 + ((k >> 2) & 1), MA_SUM); n++;
			r[n] = mk(OP_TEST, MA_SUM, MA_OFFS, 0);
			r[n].rel_b1 = 1'b1;
			r[n].first = (k == 0);
			r[n].last = (k == 7);
			n++;
		end
		r[n-1].loop = 1'b1;
		r[n-1].done = 1'b1;
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

endpackage

FILE: rtl/vfbc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfbc_mul: iterative saturating fixed-point multiplier, 16 fraction bits (Q48.16 at the default width)
// Sign-magnitude product from four half-width partial products, one a cycle.
// ----------------------------------------------------------------------------
module vfbc_mul #(
	parameter int PLANE_WIDTH = vfbc_pkg::PLANE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [PLANE_WIDTH-1:0] opa,
	input  logic signed [PLANE_WIDTH-1:0] opb,
	output logic                          done,
	output logic signed [PLANE_WIDTH-1:0] prod
);
	localparam int PW = PLANE_WIDTH;
	localparam int HB = (PW + 1) / 2;
	localparam int AW = 4 * HB;
	localparam logic [PW-1:0] VMAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic [PW-1:0] VMIN = {1'b1, {(PW-1){1'b0}}};

	logic [2*HB-1:0] ma_q, mb_q;
	logic            neg_q;
	logic [AW-1:0]   acc_q;
	logic [2:0]      step_q;
	logic            busy_q, done_q;
	logic [PW-1:0]   res_q;

	logic [PW-1:0]   mag_a, mag_b;
	logic [HB-1:0]   ha, hb;
	logic [2*HB-1:0] pp;
	logic [AW-1:0]   pp_sh;
	logic            sat;
	logic [PW-1:0]   mag;
	logic [PW-1:0]   fin;

	assign mag_a = opa[PW-1] ? (~opa + 1'b1) : opa;
	assign mag_b = opb[PW-1] ? (~opb + 1'b1) : opb;
	assign ha = step_q[1] ? ma_q[2*HB-1:HB] : ma_q[HB-1:0];
	assign hb = step_q[0] ? mb_q[2*HB-1:HB] : mb_q[HB-1:0];
	assign pp = ha * hb;

	always_comb begin
		case (step_q[1:0])
			2'd0: pp_sh = AW'(pp);
			2'd3: pp_sh = AW'(pp) << (2 * HB);
			default: pp_sh = AW'(pp) << HB;
		endcase
	end

	assign sat = |acc_q[AW-1:PW+15];
	assign mag = acc_q[PW+15:16];
	assign fin = sat ? (neg_q ? VMIN : VMAX) : (neg_q ? (~mag + 1'b1) : mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == 3'd4) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= (2*HB)'(mag_a);
			mb_q  <= (2*HB)'(mag_b);
			neg_q <= opa[PW-1] ^ opb[PW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q == 3'd4) begin
				res_q <= fin;
			end else begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign done = done_q;
	assign prod = res_q;

endmodule

FILE: rtl/vfbc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfbc_store: scratch and plane memory
// One write port, two registered read ports; entries read as zero until written.
// ----------------------------------------------------------------------------
module vfbc_store #(
	parameter int PLANE_WIDTH = vfbc_pkg::PLANE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [vfbc_pkg::MEM_AW-1:0]    waddr,
	input  logic [PLANE_WIDTH-1:0]         wdata,
	input  logic [vfbc_pkg::MEM_AW-1:0]    raddr_a,
	input  logic [vfbc_pkg::MEM_AW-1:0]    raddr_b,
	output logic [PLANE_WIDTH-1:0]         rdata_a,
	output logic [PLANE_WIDTH-1:0]         rdata_b
);
	logic [PLANE_WIDTH-1:0]         mem [vfbc_pkg::MEM_DEPTH];
	logic [vfbc_pkg::MEM_DEPTH-1:0] valid_q;
	logic [PLANE_WIDTH-1:0]         ra_q, rb_q;
	logic                           va_q, vb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_q <= mem[raddr_a];
		rb_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			va_q <= valid_q[raddr_a];
			vb_q <= valid_q[raddr_b];
		end
	end

	assign rdata_a = va_q ? ra_q : '0;
	assign rdata_b = vb_q ? rb_q : '0;

endmodule

FILE: rtl/view_frustum_box_cull.sv
`timescale 1ns / 1ps
// Axis loads, plane rebuilds and box tests run one request at a time: req_stall stays high
// while a request is in work. Every step is a micro-op on the scratch memory: add, sub,
// negate and compare go through ST_READ and ST_EXEC; a multiply goes on through ST_MUL on
// the shared 4-pass multiplier.
// Reset (arst_n low, asynchronous): config returns to defaults, axes and planes read as
// zero, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// view_frustum_box_cull: six-plane view frustum cull of axis-aligned boxes
// A microcoded sequencer runs read-modify-write steps on one scratch memory.
// ----------------------------------------------------------------------------
module view_frustum_box_cull #(
	parameter int COORD_WIDTH = vfbc_pkg::COORD_WIDTH_DEF,
	parameter int PLANE_WIDTH = vfbc_pkg::PLANE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] vec_a_x,
	input  logic [31:0] vec_a_y,
	input  logic [31:0] vec_a_z,
	input  logic [31:0] box_max_x,
	input  logic [31:0] box_max_y,
	input  logic [31:0] box_max_z,
	input  logic [31:0] entity_pos_x,
	input  logic [31:0] entity_pos_y,
	input  logic [31:0] entity_pos_z,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic        visible
);
	localparam int PW = PLANE_WIDTH;
	localparam int CW = COORD_WIDTH;
	localparam logic signed [PW-1:0] VMAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] VMIN = {1'b1, {(PW-1){1'b0}}};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	// configuration registers
	logic [17:0] tan_q;
	logic [19:0] aspect_q;
	logic [30:0] near_q;
	logic [30:0] far_q;

	// captured request operands
	logic signed [PW-1:0] a_q  [3];
	logic signed [PW-1:0] mx_q [3];
	logic signed [PW-1:0] ep_q [3];
	logic                 is_test_q;

	// sequencer
	logic [2:0]               state_q;
	logic [vfbc_pkg::PC_W-1:0] pc_q;
	logic [2:0]               idx_q;
	logic                     allout_q;
	logic                     vis_q;
	logic                     res_valid_q;
	logic                     visible_q;

	vfbc_pkg::uop_t uop;
	logic [7:0]     idx3;
	logic [7:0]     eff_a, eff_b;
	logic [6:0]     eff_d;
	logic [PW-1:0]  mem_a, mem_b;
	logic signed [PW-1:0] spec_a, spec_b;
	logic signed [PW-1:0] opa, opb;
	logic signed [PW:0]   sum_w, dif_w;
	logic signed [PW-1:0] sum_s, dif_s, neg_s, alu;
	logic           mem_we;
	logic [PW-1:0]  mem_wdata;
	logic           mul_start, mul_done;
	logic signed [PW-1:0] mul_prod;
	logic           corner_out, allout_n;
	logic           accept;
	logic           step_end;

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);

	// hold config; writes beyond the list fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_q    <= 18'd27146;
			aspect_q <= 20'd116508;
			near_q   <= 31'd6554;
			far_q    <= 31'd6553600;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				3'd0: tan_q    <= cfg_data[17:0];
				3'd1: aspect_q <= cfg_data[19:0];
				3'd2: near_q   <= cfg_data[30:0];
				3'd3: far_q    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// capture operands, sign-extending the low coordinate bits
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q[0]  <= PW'($signed(vec_a_x[CW-1:0]));
			a_q[1]  <= PW'($signed(vec_a_y[CW-1:0]));
			a_q[2]  <= PW'($signed(vec_a_z[CW-1:0]));
			mx_q[0] <= PW'($signed(box_max_x[CW-1:0]));
			mx_q[1] <= PW'($signed(box_max_y[CW-1:0]));
			mx_q[2] <= PW'($signed(box_max_z[CW-1:0]));
			ep_q[0] <= PW'($signed(entity_pos_x[CW-1:0]));
			ep_q[1] <= PW'($signed(entity_pos_y[CW-1:0]));
			ep_q[2] <= PW'($signed(entity_pos_z[CW-1:0]));
		end
	end

	// decode the current micro-op; plane-relative fields offset by the loop index
	assign uop   = vfbc_pkg::ROM[pc_q];
	assign idx3  = {4'd0, idx_q, 1'b0} + {5'd0, idx_q};
	assign eff_a = uop.src_a + (uop.rel_a3 ? idx3 : 8'd0);
	assign eff_b = uop.src_b + (uop.rel_b1 ? {5'd0, idx_q} : 8'd0);
	assign eff_d = uop.dst + (uop.rel_d3 ? idx3[6:0] : 7'd0);

	function automatic logic signed [PW-1:0] special(input logic [7:0] src,
		input logic [17:0] t, input logic [19:0] asp, input logic [30:0] nd,
		input logic [30:0] fd, input logic signed [PW-1:0] a0,
		input logic signed [PW-1:0] a1, input logic signed [PW-1:0] a2,
		input logic signed [PW-1:0] m0, input logic signed [PW-1:0] m1,
		input logic signed [PW-1:0] m2, input logic signed [PW-1:0] e0,
		input logic signed [PW-1:0] e1, input logic signed [PW-1:0] e2);
		logic signed [PW-1:0] r;
		case (src)
			vfbc_pkg::SRC_TAN:    r = PW'(t);
			vfbc_pkg::SRC_ASPECT: r = PW'(asp);
			vfbc_pkg::SRC_NEAR:   r = PW'(nd);
			vfbc_pkg::SRC_FAR:    r = PW'(fd);
			vfbc_pkg::SRC_BSCALE: r = PW'(vfbc_pkg::BOTTOM_SCALE);
			vfbc_pkg::SRC_A0:     r = a0;
			vfbc_pkg::SRC_A1:     r = a1;
			vfbc_pkg::SRC_A2:     r = a2;
			vfbc_pkg::SRC_MX0:    r = m0;
			vfbc_pkg::SRC_MX1:    r = m1;
			vfbc_pkg::SRC_MX2:    r = m2;
			vfbc_pkg::SRC_EP0:    r = e0;
			vfbc_pkg::SRC_EP1:    r = e1;
			vfbc_pkg::SRC_EP2:    r = e2;
			default:              r = '0;
		endcase
		return r;
	endfunction

	assign spec_a = special(eff_a, tan_q, aspect_q, near_q, far_q, a_q[0], a_q[1], a_q[2],
		mx_q[0], mx_q[1], mx_q[2], ep_q[0], ep_q[1], ep_q[2]);
	assign spec_b = special(eff_b, tan_q, aspect_q, near_q, far_q, a_q[0], a_q[1], a_q[2],
		mx_q[0], mx_q[1], mx_q[2], ep_q[0], ep_q[1], ep_q[2]);

	assign opa = eff_a[7] ? spec_a : $signed(mem_a);
	assign opb = eff_b[7] ? spec_b : $signed(mem_b);

	// saturating add, subtract and negate
	assign sum_w = {opa[PW-1], opa} + {opb[PW-1], opb};
	assign dif_w = {opa[PW-1], opa} - {opb[PW-1], opb};
	assign sum_s = (sum_w[PW] != sum_w[PW-1]) ? (sum_w[PW] ? VMIN : VMAX) : sum_w[PW-1:0];
	assign dif_s = (dif_w[PW] != dif_w[PW-1]) ? (dif_w[PW] ? VMIN : VMAX) : dif_w[PW-1:0];
	assign neg_s = (opa == VMIN) ? VMAX : -opa;

	always_comb begin
		case (uop.op)
			vfbc_pkg::OP_SUB: alu = dif_s;
			vfbc_pkg::OP_NEG: alu = neg_s;
			default:          alu = sum_s;
		endcase
	end

	// plane side test for one corner
	assign corner_out = vfbc_pkg::outside_pos(idx_q) ? (!sum_s[PW-1] && (sum_s != '0))
		: sum_s[PW-1];
	assign allout_n   = (uop.first ? 1'b1 : allout_q) & corner_out;

	assign mul_start = (state_q == ST_EXEC) && (uop.op == vfbc_pkg::OP_MUL);
	assign mem_we    = ((state_q == ST_EXEC) && (uop.op == vfbc_pkg::OP_ADD
		|| uop.op == vfbc_pkg::OP_SUB || uop.op == vfbc_pkg::OP_NEG))
		|| ((state_q == ST_MUL) && mul_done);
	assign mem_wdata = (state_q == ST_MUL) ? mul_prod : alu;
	assign step_end  = ((state_q == ST_EXEC) && (uop.op != vfbc_pkg::OP_MUL))
		|| ((state_q == ST_MUL) && mul_done);

	vfbc_store #(
		.PLANE_WIDTH(PLANE_WIDTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (eff_d),
		.wdata  (mem_wdata),
		.raddr_a(eff_a[6:0]),
		.raddr_b(eff_b[6:0]),
		.rdata_a(mem_a),
		.rdata_b(mem_b)
	);

	vfbc_mul #(
		.PLANE_WIDTH(PLANE_WIDTH)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.opa   (opa),
		.opb   (opb),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	// sequencer: read operands, execute, write back, advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= '0;
			idx_q     <= '0;
			allout_q  <= 1'b0;
			vis_q     <= 1'b1;
			is_test_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						is_test_q <= (req_type == vfbc_pkg::REQ_TEST);
						vis_q     <= 1'b1;
						// drop unknown request types
						case (req_type)
							vfbc_pkg::REQ_RIGHT, vfbc_pkg::REQ_UP,
							vfbc_pkg::REQ_FRONT: begin
								pc_q    <= vfbc_pkg::PC_W'(vfbc_pkg::PC_LOAD);
								idx_q   <= req_type;
								state_q <= ST_READ;
							end
							vfbc_pkg::REQ_BUILD: begin
								pc_q    <= vfbc_pkg::PC_W'(vfbc_pkg::PC_BUILD);
								idx_q   <= '0;
								state_q <= ST_READ;
							end
							vfbc_pkg::REQ_TEST: begin
								pc_q    <= vfbc_pkg::PC_W'(vfbc_pkg::PC_TEST);
								idx_q   <= '0;
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC, ST_MUL: begin
					if (state_q == ST_EXEC && uop.op == vfbc_pkg::OP_MUL) begin
						state_q <= ST_MUL;
					end
					if (state_q == ST_EXEC && uop.op == vfbc_pkg::OP_TEST) begin
						allout_q <= allout_n;
						if (uop.last && allout_n) begin
							vis_q <= 1'b0;
						end
					end
					if (step_end) begin
						if (uop.loop && idx_q != 3'(vfbc_pkg::PLANE_LAST)) begin
							idx_q   <= idx_q + 3'd1;
							pc_q    <= vfbc_pkg::PC_W'(vfbc_pkg::LOOP_START);
							state_q <= ST_READ;
						end else if (uop.done) begin
							state_q <= is_test_q ? ST_EMIT : ST_IDLE;
						end else begin
							pc_q    <= pc_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_EMIT: begin
					// hold until the result register is free
					if (!res_valid_q || !res_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && (!res_valid_q || !res_stall)) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!res_valid_q || !res_stall)) begin
			visible_q <= vis_q;
		end
	end

	assign res_valid = res_valid_q;
	assign visible   = visible_q;

`ifndef SYNTHESIS
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL))
		else $error("multiplier finished outside a multiply step");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_EXEC || state_q == ST_MUL)
		|-> (pc_q < vfbc_pkg::PC_W'(vfbc_pkg::ROM_DEPTH)))
		else $error("program counter ran past the program");
	a_emit_only_tests: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> is_test_q)
		else $error("result produced for a non-test request");
`endif

endmodule
